/* rtl/core/mpts_pkg.sv */
// ----------------------------------------------------------------------------
// mpts_pkg
// Shared types and constants of the two-phase pressure sequencer: phase
// codes, register indexes, register reset values and port widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mpts_pkg;

	// Sequencer phase. Code 3 is never produced.
	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_STOP   = 2'd2
	} phase_t;

	// Configuration port geometry. Register i lies at byte address 4*i.
	localparam int unsigned APB_ADDR_BITS = 5;
	localparam int unsigned APB_DATA_BITS = 32;
	localparam int unsigned REG_IDX_BITS  = 3;

	typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

	localparam reg_idx_t REG_PRESSURE_LIMIT = 3'd0;
	localparam reg_idx_t REG_LENGTH_ZERO    = 3'd1;
	localparam reg_idx_t REG_LENGTH_LIMIT   = 3'd2;
	localparam reg_idx_t REG_DRIVE_FIRST    = 3'd3;
	localparam reg_idx_t REG_DRIVE_SECOND   = 3'd4;

	localparam logic [15:0] RST_PRESSURE_LIMIT = 16'd8737;
	localparam logic [15:0] RST_LENGTH_ZERO    = 16'd993;
	localparam logic [15:0] RST_LENGTH_LIMIT   = 16'd243;
	localparam logic [15:0] RST_DRIVE_FIRST    = 16'hFF9C;
	localparam logic [15:0] RST_DRIVE_SECOND   = 16'd100;

	// Stream payload widths, padded to whole bytes.
	localparam int unsigned IN_DATA_BITS  = 48;
	localparam int unsigned OUT_DATA_BITS = 56;

endpackage : mpts_pkg

`default_nettype wire

/* rtl/core/mpts_rank.sv */
// ----------------------------------------------------------------------------
// mpts_rank
// Rank test of one candidate against every window entry: reports whether
// the candidate holds the median rank (WINDOW_DEPTH/2, counted from zero).
// ----------------------------------------------------------------------------
`default_nettype none

module mpts_rank #(
	parameter int unsigned WINDOW_DEPTH = 10,
	parameter int unsigned SAMPLE_BITS  = 16
) (
	input  wire logic [SAMPLE_BITS-1:0] entries [WINDOW_DEPTH],
	input  wire logic [SAMPLE_BITS-1:0] cand,
	output logic                        hit
);

	localparam int unsigned CNT_BITS = $clog2(WINDOW_DEPTH + 1);
	localparam logic [CNT_BITS-1:0] MED_RANK = CNT_BITS'(WINDOW_DEPTH / 2);

	logic [CNT_BITS-1:0] less_cnt;
	logic [CNT_BITS-1:0] equal_cnt;

	always_comb begin
		less_cnt  = '0;
		equal_cnt = '0;
		for (int j = 0; j < WINDOW_DEPTH; j++) begin
			if (entries[j] < cand) begin
				less_cnt = less_cnt + CNT_BITS'(1);
			end else if (entries[j] == cand) begin
				equal_cnt = equal_cnt + CNT_BITS'(1);
			end
		end
	end

	// The candidate covers ranks less_cnt .. less_cnt+equal_cnt-1.
	assign hit = (less_cnt <= MED_RANK) && (MED_RANK < (less_cnt + equal_cnt));

endmodule : mpts_rank

`default_nettype wire

/* rtl/core/median_pressure_two_phase_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// median_pressure_two_phase_sequencer_unit
// Two-phase actuator sequencer with a sliding-window median pressure filter
// and an APB register block for limits and drive words.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Signals                              Content
// s_*       in         s_tvalid s_tready s_tdata s_tuser    one poll item
// m_*       out        m_tvalid m_tready m_tdata            one result item
// apb       in/out     psel penable pwrite paddr pwdata ... register access
//
// An item holds the sequencer from its transfer on s_* until its result is
// loaded into the output register. In ST_SEARCH the rank test of one
// candidate per cycle tries candidates in window order until one holds the
// median rank; ST_OUT then loads the result. Aborted items and items in the
// stopped phase skip ST_SEARCH and go from ST_IDLE straight to ST_OUT.
// s_tready is high only while the sequencer is idle; a result waiting in the
// output register holds the sequencer in its final state until m_tready
// takes it. Reset clears the window, the write slot and the phase and loads
// the register defaults.
//
`default_nettype none

module median_pressure_two_phase_sequencer_unit #(
	parameter int unsigned WINDOW_DEPTH = 10,
	parameter int unsigned SAMPLE_BITS  = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Poll item stream.
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// [15:0] pressure_a, [31:16] pressure_b, [47:32] length_count
	input  wire logic [mpts_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// [0] abort
	input  wire logic                                 s_tuser,
	// Result stream.
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// [15:0] drive_a, [31:16] drive_b, [47:32] median_value, [49:48] phase,
	// [55:50] zero
	output logic [mpts_pkg::OUT_DATA_BITS-1:0]        m_tdata,
	// Register port.
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [mpts_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  wire logic [mpts_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [mpts_pkg::APB_DATA_BITS-1:0]        prdata,
	output logic                                      pready
);

	import mpts_pkg::*;

	localparam int unsigned IDX_BITS = $clog2(WINDOW_DEPTH);
	localparam int unsigned CMP_BITS = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
	localparam logic [IDX_BITS-1:0] LAST_SLOT = IDX_BITS'(WINDOW_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_OUT
	} state_t;

	// ------------------------------------------------------------------
	// Configuration registers. pready is tied high, so a write lands at
	// the access cycle of the transfer.
	// ------------------------------------------------------------------
	logic [15:0] pressure_limit_q;
	logic [15:0] length_zero_q;
	logic [15:0] length_limit_q;
	logic [15:0] drive_first_q;
	logic [15:0] drive_second_q;

	reg_idx_t reg_idx;
	logic     reg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_BITS-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressure_limit_q <= RST_PRESSURE_LIMIT;
			length_zero_q    <= RST_LENGTH_ZERO;
			length_limit_q   <= RST_LENGTH_LIMIT;
			drive_first_q    <= RST_DRIVE_FIRST;
			drive_second_q   <= RST_DRIVE_SECOND;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_PRESSURE_LIMIT: pressure_limit_q <= pwdata[15:0];
				REG_LENGTH_ZERO:    length_zero_q    <= pwdata[15:0];
				REG_LENGTH_LIMIT:   length_limit_q   <= pwdata[15:0];
				REG_DRIVE_FIRST:    drive_first_q    <= pwdata[15:0];
				REG_DRIVE_SECOND:   drive_second_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PRESSURE_LIMIT: prdata = {16'd0, pressure_limit_q};
			REG_LENGTH_ZERO:    prdata = {16'd0, length_zero_q};
			REG_LENGTH_LIMIT:   prdata = {16'd0, length_limit_q};
			REG_DRIVE_FIRST:    prdata = {16'd0, drive_first_q};
			REG_DRIVE_SECOND:   prdata = {16'd0, drive_second_q};
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer state.
	// ------------------------------------------------------------------
	state_t                  state_q;
	phase_t                  phase_q;
	logic [SAMPLE_BITS-1:0]  window_q [WINDOW_DEPTH];
	logic [IDX_BITS-1:0]     write_slot_q;
	logic [IDX_BITS-1:0]     cand_idx_q;
	logic [15:0]             length_q;

	// Result waiting for the output register.
	logic [15:0]             pend_da_q;
	logic [15:0]             pend_db_q;
	logic [15:0]             pend_med_q;
	phase_t                  pend_phase_q;

	logic                    m_tvalid_q;
	logic [OUT_DATA_BITS-1:0] m_tdata_q;

	// Incoming sample of the active phase, cut or widened to SAMPLE_BITS.
	logic [CMP_BITS-1:0]     sample_wide;
	logic [SAMPLE_BITS-1:0]  sample;
	logic                    in_xfer;

	assign sample_wide = (phase_q == PH_SECOND) ? CMP_BITS'(s_tdata[31:16])
	                                            : CMP_BITS'(s_tdata[15:0]);
	assign sample      = sample_wide[SAMPLE_BITS-1:0];
	assign s_tready    = (state_q == ST_IDLE);
	assign in_xfer     = s_tvalid && s_tready;

	// Candidate under test and the shared rank unit.
	logic [SAMPLE_BITS-1:0]  cand;
	logic                    cand_hit;

	assign cand = window_q[cand_idx_q];

	mpts_rank #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_rank (
		.entries(window_q),
		.cand   (cand),
		.hit    (cand_hit)
	);

	// Decision terms for the candidate that wins the rank test.
	logic [CMP_BITS-1:0]     med_wide;
	logic                    med_over;
	logic signed [16:0]      extension;
	logic                    ext_over;

	assign med_wide  = CMP_BITS'(cand);
	assign med_over  = med_wide > CMP_BITS'(pressure_limit_q);
	// The difference of two unsigned 16-bit counts fits a 17-bit signed word.
	assign extension = $signed({1'b0, length_q}) - $signed({1'b0, length_zero_q});
	assign ext_over  = extension > $signed({1'b0, length_limit_q});

	logic                    out_free;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_FIRST;
			write_slot_q <= '0;
			cand_idx_q   <= '0;
			length_q     <= '0;
			pend_da_q    <= '0;
			pend_db_q    <= '0;
			pend_med_q   <= '0;
			pend_phase_q <= PH_FIRST;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				window_q[i] <= '0;
			end
		end else begin
			// In ST_OUT the output register is reloaded whenever it is taken.
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						length_q <= s_tdata[47:32];
						if (s_tuser || (phase_q != PH_FIRST && phase_q != PH_SECOND)) begin
							// Abort, or already stopped: no sample enters the window.
							phase_q      <= PH_STOP;
							pend_da_q    <= '0;
							pend_db_q    <= '0;
							pend_med_q   <= '0;
							pend_phase_q <= PH_STOP;
							state_q      <= ST_OUT;
						end else begin
							window_q[write_slot_q] <= sample;
							write_slot_q <= (write_slot_q == LAST_SLOT) ? '0
							                : write_slot_q + IDX_BITS'(1);
							cand_idx_q   <= '0;
							state_q      <= ST_SEARCH;
						end
					end
				end

				ST_SEARCH: begin
					if (!cand_hit) begin
						// Some entry always holds the median rank, so the index
						// never runs past the last slot.
						cand_idx_q <= cand_idx_q + IDX_BITS'(1);
					end else begin
						pend_med_q <= med_wide[15:0];
						state_q    <= ST_OUT;
						if (phase_q == PH_FIRST) begin
							if (med_over) begin
								// Second phase starts on an empty window.
								for (int i = 0; i < WINDOW_DEPTH; i++) begin
									window_q[i] <= '0;
								end
								write_slot_q <= '0;
								phase_q      <= PH_SECOND;
								pend_phase_q <= PH_SECOND;
								pend_da_q    <= '0;
								pend_db_q    <= drive_second_q;
							end else begin
								pend_phase_q <= PH_FIRST;
								pend_da_q    <= drive_first_q;
								pend_db_q    <= '0;
							end
						end else begin
							pend_da_q <= '0;
							if (med_over || ext_over) begin
								phase_q      <= PH_STOP;
								pend_phase_q <= PH_STOP;
								pend_db_q    <= '0;
							end else begin
								pend_phase_q <= PH_SECOND;
								pend_db_q    <= drive_second_q;
							end
						end
					end
				end

				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'd0, pend_phase_q, pend_med_q, pend_db_q, pend_da_q};
						state_q    <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule : median_pressure_two_phase_sequencer_unit

`default_nettype wire

/* test/tb_median_pressure_two_phase_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// tb_median_pressure_two_phase_sequencer_unit
// Self-checking bench for the two-phase pressure sequencer. A predictor keeps
// its own copy of the sliding window, the write slot, the phase and the
// registers, and works out the result of every accepted poll transfer. The
// results that come out of the block are checked field by field in order.
// Stimulus walks the one-way phase sequence once: a long first phase, a
// crossing into the second phase, a long second phase, one way of stopping,
// and a stopped tail. Both stream sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_median_pressure_two_phase_sequencer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mpts_pkg::*;

	localparam int DEPTH       = 10;
	localparam int MID         = DEPTH / 2;
	localparam int CYCLE_LIMIT = 600000;

	// One poll item as it travels on the slave side.
	typedef struct packed {
		logic [15:0] length_count;
		logic [15:0] pressure_b;
		logic [15:0] pressure_a;
		logic        abort;
	} poll_t;

	// One predicted result item.
	typedef struct packed {
		logic [15:0] drive_a;
		logic [15:0] drive_b;
		logic [15:0] median;
		phase_t      ph;
	} outcome_t;

	// Predictor plus ordered store of the results that are still due.
	class pressure_scoreboard;
		logic [15:0] win [DEPTH];
		int unsigned slot;
		phase_t      phase;
		logic [15:0] cfg [5];
		outcome_t    due_results [$];
		int unsigned mismatches;
		int unsigned polls;
		int unsigned checked;

		function new();
			foreach (win[i]) win[i] = '0;
			slot = 0;
			phase = PH_FIRST;
			cfg[REG_PRESSURE_LIMIT] = RST_PRESSURE_LIMIT;
			cfg[REG_LENGTH_ZERO]    = RST_LENGTH_ZERO;
			cfg[REG_LENGTH_LIMIT]   = RST_LENGTH_LIMIT;
			cfg[REG_DRIVE_FIRST]    = RST_DRIVE_FIRST;
			cfg[REG_DRIVE_SECOND]   = RST_DRIVE_SECOND;
			mismatches = 0;
			polls = 0;
			checked = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [15:0] value);
			cfg[idx] = value;
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction

		// The entry whose rank in ascending order is MID; ties are resolved by
		// counting equal entries, so repeated values are handled exactly.
		function logic [15:0] window_median();
			int unsigned below, same;
			for (int i = 0; i < DEPTH; i++) begin
				below = 0;
				same = 0;
				for (int j = 0; j < DEPTH; j++) begin
					if (win[j] < win[i])
						below++;
					else if (win[j] == win[i])
						same++;
				end
				if (below <= MID && MID < below + same)
					return win[i];
			end
			return '0;
		endfunction

		// Median the window would have if this sample went in next.
		function logic [15:0] median_with(logic [15:0] sample);
			logic [15:0] kept;
			logic [15:0] m;
			kept = win[slot];
			win[slot] = sample;
			m = window_median();
			win[slot] = kept;
			return m;
		endfunction

		function void push_sample(logic [15:0] sample);
			win[slot] = sample;
			slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH %s: expected %h, got %h (after %0d results)",
					what, want, got, checked);
		endfunction

		// Advance the sequencer by one accepted poll and queue its result.
		function void take_poll(poll_t p);
			outcome_t o;
			int       ext;
			o = '{drive_a: '0, drive_b: '0, median: '0, ph: PH_STOP};
			polls++;
			if (p.abort) begin
				phase = PH_STOP;
			end else if (phase == PH_FIRST) begin
				push_sample(p.pressure_a);
				o.median = window_median();
				if (o.median > cfg[REG_PRESSURE_LIMIT]) begin
					// The window starts over for the second sensor.
					foreach (win[i]) win[i] = '0;
					slot = 0;
					phase = PH_SECOND;
					o.drive_b = cfg[REG_DRIVE_SECOND];
				end else begin
					o.drive_a = cfg[REG_DRIVE_FIRST];
				end
			end else if (phase == PH_SECOND) begin
				push_sample(p.pressure_b);
				o.median = window_median();
				ext = int'(p.length_count) - int'(cfg[REG_LENGTH_ZERO]);
				if (o.median > cfg[REG_PRESSURE_LIMIT] || ext > int'(cfg[REG_LENGTH_LIMIT]))
					phase = PH_STOP;
				else
					o.drive_b = cfg[REG_DRIVE_SECOND];
			end else begin
				phase = PH_STOP;
			end
			o.ph = phase;
			due_results.push_back(o);
		endfunction

		function void match_result(logic [OUT_DATA_BITS-1:0] word);
			outcome_t e;
			if (due_results.size() == 0) begin
				flag("result with nothing due", '0, word[31:0]);
				return;
			end
			e = due_results.pop_front();
			checked++;
			if (word[15:0] !== e.drive_a)
				flag("drive_a", 32'(e.drive_a), 32'(word[15:0]));
			if (word[31:16] !== e.drive_b)
				flag("drive_b", 32'(e.drive_b), 32'(word[31:16]));
			if (word[47:32] !== e.median)
				flag("median_value", 32'(e.median), 32'(word[47:32]));
			if (word[49:48] !== e.ph)
				flag("phase", 32'(e.ph), 32'(word[49:48]));
			if (word[55:50] !== '0)
				flag("tdata padding", '0, 32'(word[55:50]));
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;   // [15:0] pressure_a, [31:16] pressure_b, [47:32] length_count
	logic                     s_tuser;   // [0] abort
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;   // [15:0] drive_a, [31:16] drive_b, [47:32] median_value,
	                                     // [49:48] phase, [55:50] zero
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	pressure_scoreboard sb;
	bit                 steady;   // no stalls on either side while set
	int unsigned        sent;
	int unsigned        cycles;

	median_pressure_two_phase_sequencer_unit #(
		.WINDOW_DEPTH(DEPTH),
		.SAMPLE_BITS (16)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// The receiver stalls about one cycle in five, except in the steady stretch.
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 21);
	end

	// Every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.match_result(m_tdata);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles, sb.pending());
			$display("median_pressure_two_phase_sequencer_unit verification failed");
			$finish;
		end
	end

	// One APB access: a setup cycle, then an access cycle that completes at the
	// rising edge where pready is seen high.
	task automatic reg_access(input bit wr, input reg_idx_t idx, input logic [15:0] value,
			output logic [15:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), value};   // upper bits are not part of any register
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata[15:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Write a register, tell the predictor, and read the value back.
	task automatic set_reg(input reg_idx_t idx, input logic [15:0] value);
		logic [15:0] rd;
		reg_access(1'b1, idx, value, rd);
		sb.write_reg(idx, value);
		reg_access(1'b0, idx, '0, rd);
		if (rd !== value)
			sb.flag($sformatf("read back of register %0d", idx), 32'(value), 32'(rd));
	endtask

	// Offer one poll item and wait for its transfer. The valid stays high into
	// the next call, so back-to-back items never see it dropped and raised in
	// the same step.
	task automatic send_poll(input logic [15:0] pa, input logic [15:0] pb,
			input logic [15:0] len, input logic stop_req);
		poll_t p;
		p = '{length_count: len, pressure_b: pb, pressure_a: pa, abort: stop_req};
		steady = (sent >= 600 && sent < 800);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 21) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {p.length_count, p.pressure_b, p.pressure_a};
		s_tuser  <= p.abort;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.take_poll(p);
		sent++;
	endtask

	// Stop offering items and wait until every predicted result has arrived.
	// Registers are only written after this, with the block idle.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// A pressure sample biased toward small values with many repeats, toward
	// the limit, and across the full range.
	function automatic logic [15:0] pick_pressure();
		int v;
		case ($urandom_range(0, 2))
			0: v = $urandom_range(0, 65535);
			1: v = $urandom_range(0, 15);
			default: v = int'(sb.cfg[REG_PRESSURE_LIMIT]) + int'($urandom_range(0, 4)) - 2;
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	// A sample that keeps the current phase going. If the window median would
	// pass the limit, a value at or below the limit is used instead; that never
	// adds an entry above the limit, so the median cannot pass it.
	function automatic logic [15:0] stay_pressure();
		logic [15:0] s;
		s = pick_pressure();
		if (sb.median_with(s) > sb.cfg[REG_PRESSURE_LIMIT])
			s = 16'($urandom_range(0, sb.cfg[REG_PRESSURE_LIMIT]));
		return s;
	endfunction

	// A length count whose extension stays within the limit: often right on
	// the boundary, often below the zero point.
	function automatic logic [15:0] stay_length();
		int z, top;
		z = sb.cfg[REG_LENGTH_ZERO];
		top = z + int'(sb.cfg[REG_LENGTH_LIMIT]);
		if (top > 65535)
			top = 65535;
		case ($urandom_range(0, 3))
			0: return 16'(top);
			1: return (z > 0) ? 16'($urandom_range(0, z - 1)) : 16'd0;
			default: return 16'($urandom_range(0, top));
		endcase
	endfunction

	// A pressure limit that the present window does not already pass.
	function automatic logic [15:0] pick_limit();
		int m;
		m = sb.window_median();
		case ($urandom_range(0, 3))
			0: return 16'(m);
			1: return 16'hFFFF;
			default: return 16'($urandom_range(m, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int          n;
		int          mode;
		int          z;
		int          ll;
		logic [15:0] lim;
		logic [15:0] v;
		logic [15:0] rd;
		int unsigned first_polls;
		string       how;

		sb = new();
		steady   = 1'b0;
		sent     = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Registers must come out of reset with their documented defaults.
		for (int i = REG_PRESSURE_LIMIT; i <= REG_DRIVE_SECOND; i++) begin
			reg_access(1'b0, reg_idx_t'(i), '0, rd);
			if (rd !== sb.cfg[i])
				sb.flag($sformatf("reset value of register %0d", i),
					32'(sb.cfg[i]), 32'(rd));
		end

		// First phase with the reset limit. Four samples above the limit plus one
		// sample equal to it leave the median exactly on the limit, which must not
		// end the phase. The unused fields take extreme and alternating bit patterns.
		send_poll(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
		send_poll(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
		send_poll(RST_PRESSURE_LIMIT, 16'hAAAA, 16'h5555, 1'b0);
		send_poll(RST_PRESSURE_LIMIT + 16'd1, 16'h5555, 16'hAAAA, 1'b0);
		send_poll(16'hAAAA, 16'hFFFF, 16'h0000, 1'b0);
		send_poll(16'h5555, 16'h0000, 16'hFFFF, 1'b0);
		send_poll(16'h0001, 16'h8000, 16'h7FFF, 1'b0);

		// Long first phase in chunks, each with its own registers. The median
		// never passes the limit, so the window keeps sliding.
		for (int c = 0; c < 6; c++) begin
			settle();
			set_reg(REG_DRIVE_FIRST, (c == 0) ? 16'h8000 : (c == 1) ? 16'h7FFF : pick_word());
			set_reg(REG_PRESSURE_LIMIT, (c == 0) ? 16'hFFFF : pick_limit());
			set_reg(REG_LENGTH_ZERO, pick_word());
			set_reg(REG_LENGTH_LIMIT, pick_word());
			repeat ($urandom_range(120, 160))
				send_poll(stay_pressure(), 16'($urandom), 16'($urandom), 1'b0);
		end

		// Cross into the second phase: mostly samples above a mid-range limit,
		// only those after twenty items.
		settle();
		lim = 16'($urandom_range(1000, 60000));
		set_reg(REG_PRESSURE_LIMIT, lim);
		set_reg(REG_DRIVE_SECOND, 16'h8000);
		n = 0;
		while (sb.phase == PH_FIRST) begin
			v = (n >= 20 || $urandom_range(0, 9) < 7) ?
				16'($urandom_range(int'(lim) + 1, 65535)) : 16'($urandom);
			send_poll(v, 16'($urandom), 16'($urandom), 1'b0);
			n++;
		end
		first_polls = sb.polls;

		// Second phase, directed: a zero limit on the freshly cleared window, then
		// extensions far below zero, just below it and exactly on a zero limit,
		// then the largest extension that still keeps the phase alive.
		settle();
		set_reg(REG_PRESSURE_LIMIT, 16'h0000);
		set_reg(REG_LENGTH_ZERO, 16'hFFFF);
		set_reg(REG_LENGTH_LIMIT, 16'h0000);
		send_poll(16'($urandom), stay_pressure(), 16'h0000, 1'b0);
		send_poll(16'($urandom), stay_pressure(), 16'hFFFE, 1'b0);
		send_poll(16'($urandom), stay_pressure(), 16'hFFFF, 1'b0);
		settle();
		set_reg(REG_LENGTH_ZERO, 16'h0000);
		set_reg(REG_LENGTH_LIMIT, 16'hFFFF);
		set_reg(REG_DRIVE_SECOND, 16'h7FFF);
		send_poll(16'($urandom), stay_pressure(), 16'hFFFF, 1'b0);
		send_poll(16'($urandom), stay_pressure(), 16'h0000, 1'b0);

		// Long second phase in chunks; neither the median nor the extension ends it.
		for (int c = 0; c < 6; c++) begin
			settle();
			set_reg(REG_DRIVE_SECOND, (c == 0) ? 16'h0000 : pick_word());
			set_reg(REG_PRESSURE_LIMIT, pick_limit());
			set_reg(REG_LENGTH_ZERO, pick_word());
			set_reg(REG_LENGTH_LIMIT, pick_word());
			repeat ($urandom_range(120, 160))
				send_poll(16'($urandom), stay_pressure(), stay_length(), 1'b0);
		end

		// End the second phase one of three ways, chosen by the seed.
		settle();
		mode = $urandom_range(0, 2);
		if (mode == 0) begin
			how = "the pressure median";
			// The limit stays below the top code so that samples can pass it.
			z = int'(sb.window_median());
			if (z > 65534)
				z = 65534;
			lim = 16'($urandom_range(z, 65534));
			set_reg(REG_PRESSURE_LIMIT, lim);
			n = 0;
			while (sb.phase == PH_SECOND) begin
				v = (n >= 20 || $urandom_range(0, 9) < 7) ?
					16'($urandom_range(int'(lim) + 1, 65535)) : 16'($urandom);
				send_poll(16'($urandom), v, stay_length(), 1'b0);
				n++;
			end
		end else if (mode == 1) begin
			how = "the length extension";
			z = $urandom_range(0, 30000);
			ll = $urandom_range(0, 30000);
			set_reg(REG_LENGTH_ZERO, 16'(z));
			set_reg(REG_LENGTH_LIMIT, 16'(ll));
			repeat (3)
				send_poll(16'($urandom), stay_pressure(), stay_length(), 1'b0);
			send_poll(16'($urandom), stay_pressure(),
				16'($urandom_range(z + ll + 1, 65535)), 1'b0);
		end else begin
			how = "abort";
			send_poll(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
		end

		// Stopped for good: everything, abort included, is ignored.
		repeat (20)
			send_poll(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));

		settle();
		repeat (2 * DEPTH) @(posedge clk);

		$display("%0d poll transfers and %0d result transfers checked, %0d mismatches",
			sb.polls, sb.checked, sb.mismatches);
		$display("first phase left after %0d polls, second phase ended by %s",
			first_polls, how);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("median_pressure_two_phase_sequencer_unit verification clean");
		end else begin
			$display("%0d results never arrived", sb.pending());
			$display("median_pressure_two_phase_sequencer_unit verification failed");
		end
		$finish;
	end

endmodule : tb_median_pressure_two_phase_sequencer_unit

`default_nettype wire

/* sim.f */
rtl/core/mpts_pkg.sv
rtl/core/mpts_rank.sv
rtl/core/median_pressure_two_phase_sequencer_unit.sv
test/tb_median_pressure_two_phase_sequencer_unit.sv
